// ----- rtl/qaar_pkg.sv -----
// ----------------------------------------------------------------------------
// qaar_pkg
// Shared types and constants of the quaternion axis-angle rotate unit.
// ----------------------------------------------------------------------------
package qaar_pkg;

  localparam int CordicSteps = 30;
  localparam int QFrac       = 24;
  localparam logic signed [32:0] CordicGain = 33'sd652032874;

  // arctan(2^-i) in units of 2^-32 of a turn, as a half-angle phase
  localparam logic [31:0] ATAN_TAB [CordicSteps] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  // CORDIC vector: x -> cosine, y -> sine, z -> residual phase
  typedef struct packed {
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [32:0] z;
    logic               neg;
  } cs_t;

  // point and axis riding along with the CORDIC vector
  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
  } item_t;

endpackage

// ----- rtl/qaar_req_if.sv -----
// ----------------------------------------------------------------------------
// qaar_req_if
// Request channel: point, axis and angle with valid/ready.
// ----------------------------------------------------------------------------
interface qaar_req_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic signed [15:0] axis_x;
  logic signed [15:0] axis_y;
  logic signed [15:0] axis_z;
  logic        [15:0] angle;

  modport source (output valid, point_x, point_y, point_z, axis_x, axis_y, axis_z,
                  angle, input ready);
  modport sink   (input valid, point_x, point_y, point_z, axis_x, axis_y, axis_z,
                  angle, output ready);
endinterface

// ----- rtl/qaar_rsp_if.sv -----
// ----------------------------------------------------------------------------
// qaar_rsp_if
// Response channel: rotated point with valid/ready.
// ----------------------------------------------------------------------------
interface qaar_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] rotated_x;
  logic signed [31:0] rotated_y;
  logic signed [31:0] rotated_z;

  modport source (output valid, rotated_x, rotated_y, rotated_z, input ready);
  modport sink   (input valid, rotated_x, rotated_y, rotated_z, output ready);
endinterface

// ----- rtl/qaar_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// qaar_cordic_cell
// One rotation-mode CORDIC micro-rotation with its pipeline register.
// ----------------------------------------------------------------------------
module qaar_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  qaar_pkg::cs_t   in_cs,
  input  qaar_pkg::item_t in_item,
  output logic            out_valid,
  output qaar_pkg::cs_t   out_cs,
  output qaar_pkg::item_t out_item
);

  localparam logic signed [32:0] Atan = {1'b0, qaar_pkg::ATAN_TAB[STEP]};

  qaar_pkg::cs_t      cs_next;
  logic signed [32:0] xs;
  logic signed [32:0] ys;

  always_comb begin
    xs = in_cs.x >>> STEP;
    ys = in_cs.y >>> STEP;
    cs_next = in_cs;
    if (!in_cs.z[32]) begin
      cs_next.x = in_cs.x - ys;
      cs_next.y = in_cs.y + xs;
      cs_next.z = in_cs.z - Atan;
    end else begin
      cs_next.x = in_cs.x + ys;
      cs_next.y = in_cs.y - xs;
      cs_next.z = in_cs.z + Atan;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_cs   <= cs_next;
      out_item <= in_item;
    end
  end

endmodule

// ----- rtl/qaar_qmul.sv -----
// ----------------------------------------------------------------------------
// qaar_qmul
// Builds q from sin/cos and axis, then the two Hamilton products q*p*conj(q)
// in five registered stages, the last being the output register.
// ----------------------------------------------------------------------------
module qaar_qmul (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  qaar_pkg::cs_t      in_cs,
  input  qaar_pkg::item_t    in_item,
  output logic               out_valid,
  output logic signed [31:0] rot_x,
  output logic signed [31:0] rot_y,
  output logic signed [31:0] rot_z
);

  localparam int Sh = qaar_pkg::QFrac;

  logic [3:0] v;

  // stage 1: quaternion
  logic signed [32:0] cosv;
  logic signed [48:0] sa [3];
  logic signed [26:0] w;
  logic signed [27:0] q [3];
  logic signed [31:0] p [3];

  // stage 2: first products
  logic signed [59:0] m [12];
  logic signed [26:0] w2;
  logic signed [27:0] q2 [3];

  // stage 3: t = q * (0, p)
  logic signed [61:0] ts [4];
  logic signed [37:0] t [4];
  logic signed [37:0] t_r [4];
  logic signed [26:0] w3;
  logic signed [27:0] q3 [3];

  // stage 4: second products
  logic signed [65:0] n [12];

  // stage 5: r = t * conj(q)
  logic signed [67:0] rs [3];
  logic signed [43:0] rr [3];
  logic signed [31:0] rsat [3];

  always_comb begin
    cosv  = in_cs.neg ? -in_cs.x : in_cs.x;
    sa[0] = in_cs.y * in_item.ax;
    sa[1] = in_cs.y * in_item.ay;
    sa[2] = in_cs.y * in_item.az;
  end

  always_comb begin
    ts[0] = -m[0] - m[1] - m[2];
    ts[1] =  m[3] + m[4] - m[5];
    ts[2] =  m[6] - m[7] + m[8];
    ts[3] =  m[9] + m[10] - m[11];
    for (int k = 0; k < 4; k++) begin
      t[k] = 38'((ts[k] + (62'sd1 <<< (Sh - 1))) >>> Sh);
    end
  end

  always_comb begin
    rs[0] = -n[0] + n[1] - n[2]  + n[3];
    rs[1] = -n[4] + n[5] + n[6]  - n[7];
    rs[2] = -n[8] - n[9] + n[10] + n[11];
    for (int k = 0; k < 3; k++) begin
      rr[k] = 44'((rs[k] + (68'sd1 <<< (Sh - 1))) >>> Sh);
      if (rr[k] > 44'sh0007FFFFFFF) begin
        rsat[k] = 32'sh7FFFFFFF;
      end else if (rr[k] < -44'sh00080000000) begin
        rsat[k] = 32'sh80000000;
      end else begin
        rsat[k] = rr[k][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      v <= {v[2:0], in_valid};
      out_valid <= v[3];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w    <= 27'((cosv + 33'sd32) >>> 6);
      q[0] <= 28'((sa[0] + 49'sd524288) >>> 20);
      q[1] <= 28'((sa[1] + 49'sd524288) >>> 20);
      q[2] <= 28'((sa[2] + 49'sd524288) >>> 20);
      p[0] <= in_item.px;
      p[1] <= in_item.py;
      p[2] <= in_item.pz;

      m[0]  <= q[0] * p[0];
      m[1]  <= q[1] * p[1];
      m[2]  <= q[2] * p[2];
      m[3]  <= w * p[0];
      m[4]  <= q[1] * p[2];
      m[5]  <= q[2] * p[1];
      m[6]  <= w * p[1];
      m[7]  <= q[0] * p[2];
      m[8]  <= q[2] * p[0];
      m[9]  <= w * p[2];
      m[10] <= q[0] * p[1];
      m[11] <= q[1] * p[0];
      w2    <= w;
      q2    <= q;

      w3 <= w2;
      q3 <= q2;
      for (int k = 0; k < 4; k++) begin
        t_r[k] <= t[k];
      end

      n[0]  <= t_r[0] * q3[0];
      n[1]  <= t_r[1] * w3;
      n[2]  <= t_r[2] * q3[2];
      n[3]  <= t_r[3] * q3[1];
      n[4]  <= t_r[0] * q3[1];
      n[5]  <= t_r[1] * q3[2];
      n[6]  <= t_r[2] * w3;
      n[7]  <= t_r[3] * q3[0];
      n[8]  <= t_r[0] * q3[2];
      n[9]  <= t_r[1] * q3[1];
      n[10] <= t_r[2] * q3[0];
      n[11] <= t_r[3] * w3;

      rot_x <= rsat[0];
      rot_y <= rsat[1];
      rot_z <= rsat[2];
    end
  end

endmodule

// ----- rtl/quaternion_axis_angle_rotate_unit.sv -----
// ----------------------------------------------------------------------------
// quaternion_axis_angle_rotate_unit
// Rotates a Q16.16 point by an axis (Q1.14, not normalized) and a binary angle.
// ----------------------------------------------------------------------------
// Fully pipelined: one request per cycle unless stalled, passing through one
// phase-reduction stage, a row of 30 CORDIC cells for sin/cos of the half
// angle, then five stages of quaternion products. The whole pipeline holds
// while a result waits at the output and response ready is low; a new request
// is taken whenever the output register is empty or being drained.
module quaternion_axis_angle_rotate_unit #(
  parameter int ANGLE_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  qaar_req_if.sink  req,
  qaar_rsp_if.source rsp
);

  localparam int Steps = qaar_pkg::CordicSteps;
  localparam int PhSh  = 31 - ANGLE_BITS;

  logic en;
  logic [31:0] ang_m;
  logic [31:0] ph;
  logic [31:0] ph_m;
  logic        mirror;

  logic            cv  [Steps + 1];
  qaar_pkg::cs_t   ccs [Steps + 1];
  qaar_pkg::item_t cit [Steps + 1];
  qaar_pkg::cs_t   cs_next;
  qaar_pkg::item_t item_next;

  assign en        = !rsp.valid || rsp.ready;
  assign req.ready = en;

  always_comb begin
    ang_m  = 32'(req.angle) & ((32'd1 << ANGLE_BITS) - 32'd1);
    ph     = ang_m << PhSh;
    mirror = ph > (32'd1 << 30);
    ph_m   = mirror ? (32'd1 << 31) - ph : ph;
    cs_next.x   = qaar_pkg::CordicGain;
    cs_next.y   = '0;
    cs_next.z   = {1'b0, ph_m};
    cs_next.neg = mirror;
    item_next.px = req.point_x;
    item_next.py = req.point_y;
    item_next.pz = req.point_z;
    item_next.ax = req.axis_x;
    item_next.ay = req.axis_y;
    item_next.az = req.axis_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else if (en) begin
      cv[0] <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ccs[0] <= cs_next;
      cit[0] <= item_next;
    end
  end

  for (genvar i = 0; i < Steps; i++) begin : g_cell
    qaar_cordic_cell #(.STEP(i)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (cv[i]),
      .in_cs    (ccs[i]),
      .in_item  (cit[i]),
      .out_valid(cv[i + 1]),
      .out_cs   (ccs[i + 1]),
      .out_item (cit[i + 1])
    );
  end

  qaar_qmul u_qmul (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (cv[Steps]),
    .in_cs    (ccs[Steps]),
    .in_item  (cit[Steps]),
    .out_valid(rsp.valid),
    .rot_x    (rsp.rotated_x),
    .rot_y    (rsp.rotated_y),
    .rot_z    (rsp.rotated_z)
  );

  // residual phase after the last micro-rotation stays tiny
  a_cordic_converged: assert property (@(posedge clk) disable iff (rst)
    cv[Steps] |-> (ccs[Steps].z < 33'sd64 && ccs[Steps].z > -33'sd64))
    else $error("CORDIC residual phase out of bound");

  // sin/cos stay within unit magnitude plus rounding slack
  a_cordic_bounded: assert property (@(posedge clk) disable iff (rst)
    cv[Steps] |-> (ccs[Steps].x < 33'sd1073742848 && ccs[Steps].x > -33'sd1073742848 &&
                   ccs[Steps].y < 33'sd1073742848 && ccs[Steps].y > -33'sd1073742848))
    else $error("CORDIC output magnitude out of bound");

  // a stalled pipeline keeps its CORDIC output
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (!en && cv[Steps]) |=> (cv[Steps] && $stable(ccs[Steps])))
    else $error("CORDIC row moved during stall");

endmodule
